@@ hdl/tcw_pkg.sv @@
// Shared constants, types and helpers of the text console writer.
package tcw_pkg;

	localparam int ROWS_DEF = 25;
	localparam int COLS_DEF = 80;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] BLANK_CODE   = 8'd0;

	localparam logic [7:0] REG_FORE = 8'd0;
	localparam logic [7:0] REG_BACK = 8'd1;

	localparam logic [3:0] FORE_RESET = 4'd2;
	localparam logic [3:0] BACK_RESET = 4'd0;

	typedef struct packed {
		logic [3:0] back;
		logic [3:0] fore;
		logic [7:0] code;
	} cell_t;

	function automatic cell_t make_cell(logic [7:0] code, logic [3:0] fore, logic [3:0] back);
		cell_t c;
		c.code = code;
		c.fore = fore;
		c.back = back;
		return c;
	endfunction

endpackage

@@ hdl/text_console_writer_top.sv @@
// Text console writer: cursor control and sequencing around one screen cell memory.
// Plain character, read and unused op: the result is loaded in S_PUT, one item at a time.
// Newline: blanks fill the rest of the row in S_NLFILL, one blank cell written per cycle.
// A pending scroll first moves the rows up in S_SCROLL (one read and one write port per cycle).
// Clear: a blank is written to every cell in S_CLEAR. Results sit in an output register, the next item may enter.
// After reset a clearing pass in S_INIT zeroes the memory; in_ready stays low.
module text_console_writer_top #(
	parameter int ROWS = tcw_pkg::ROWS_DEF,
	parameter int COLS = tcw_pkg::COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  char_code,
	input  logic [10:0] cell_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_code,
	output logic [3:0]  read_fore,
	output logic [3:0]  read_back,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_col
);

	localparam int CELLS    = ROWS * COLS;
	localparam int SCROLL_N = CELLS - COLS;
	localparam int AW       = $clog2(CELLS);
	localparam int CW       = $clog2(CELLS + 1);
	localparam int RW       = $clog2(ROWS + 1);
	localparam int LW       = $clog2(COLS);

	typedef enum logic [6:0] {
		S_INIT   = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_SCROLL = 7'b0000100,
		S_WCHAR  = 7'b0001000,
		S_NLFILL = 7'b0010000,
		S_CLEAR  = 7'b0100000,
		S_PUT    = 7'b1000000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [RW-1:0]   row_q;
	logic [LW-1:0]   col_q;
	logic [3:0]      fore_q;
	logic [3:0]      back_q;
	logic            rd_sel_q;
	logic            pend_s1;
	logic [AW-1:0]   waddr_s1;
	logic [7:0]      code_q;
	logic            out_valid_q;
	tcw_pkg::cell_t  rdata_q;
	tcw_pkg::cell_t  mem [CELLS];

	logic            accept;
	logic            act_idle;
	logic [7:0]      code_sel;
	logic            is_nl;
	logic            in_range;
	logic            row_full;
	logic            col_last;
	logic            out_load;
	logic [AW-1:0]   cur_addr;
	logic [AW+10:0]  idx_x;
	logic [RW+4:0]   row_x;
	logic [LW+6:0]   col_x;
	tcw_pkg::cell_t  blank;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	tcw_pkg::cell_t  mem_wdata;
	logic            mem_re;
	logic [AW-1:0]   mem_raddr;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	assign accept   = in_valid && in_ready;
	assign row_full = (row_q == RW'(ROWS));
	assign col_last = (col_q == LW'(COLS - 1));
	assign act_idle = accept && (op == tcw_pkg::OP_WRITE) && !row_full;
	assign code_sel = (state_q == S_WCHAR) ? code_q : char_code;
	assign is_nl    = (code_sel == tcw_pkg::NEWLINE_CODE);
	assign in_range = (32'(cell_index) < CELLS);
	assign idx_x    = {{AW{1'b0}}, cell_index};
	assign cur_addr = AW'(32'(row_q) * COLS + 32'(col_q));
	assign blank    = tcw_pkg::make_cell(tcw_pkg::BLANK_CODE, fore_q, back_q);
	assign out_load = (state_q == S_PUT) && (!out_valid_q || out_ready);
	assign row_x    = {5'd0, row_q};
	assign col_x    = {7'd0, col_q};

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_addr;
		mem_wdata = blank;
		mem_re    = 1'b0;
		mem_raddr = idx_x[AW-1:0];
		unique case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q[AW-1:0];
				mem_wdata = '0;
			end
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q[AW-1:0];
			end
			S_SCROLL: begin
				// read one row ahead, write back the word fetched last cycle
				mem_re    = (32'(cnt_q) < SCROLL_N);
				mem_raddr = AW'(32'(cnt_q) + COLS);
				mem_we    = pend_s1;
				mem_waddr = waddr_s1;
				mem_wdata = rdata_q;
			end
			S_NLFILL: begin
				mem_we = 1'b1;
			end
			S_IDLE: begin
				if (act_idle && !is_nl) begin
					mem_we    = 1'b1;
					mem_wdata = tcw_pkg::make_cell(code_sel, fore_q, back_q);
				end
				mem_re = accept && (op == tcw_pkg::OP_READ) && in_range;
			end
			S_WCHAR: begin
				if (!is_nl) begin
					mem_we    = 1'b1;
					mem_wdata = tcw_pkg::make_cell(code_sel, fore_q, back_q);
				end
			end
			S_PUT: begin
				mem_we = 1'b0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fore_q <= tcw_pkg::FORE_RESET;
			back_q <= tcw_pkg::BACK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == tcw_pkg::REG_FORE) begin
				fore_q <= cfg_data;
			end else if (cfg_index == tcw_pkg::REG_BACK) begin
				back_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			cnt_q    <= '0;
			row_q    <= '0;
			col_q    <= '0;
			rd_sel_q <= 1'b0;
			pend_s1  <= 1'b0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						rd_sel_q <= (op == tcw_pkg::OP_READ) && in_range;
						unique case (op)
							tcw_pkg::OP_WRITE: begin
								if (row_full) begin
									cnt_q   <= '0;
									state_q <= S_SCROLL;
								end else if (is_nl) begin
									state_q <= S_NLFILL;
								end else begin
									state_q <= S_PUT;
									if (col_last) begin
										col_q <= '0;
										row_q <= row_q + RW'(1);
									end else begin
										col_q <= col_q + LW'(1);
									end
								end
							end
							tcw_pkg::OP_CLEAR: begin
								row_q   <= '0;
								col_q   <= '0;
								cnt_q   <= '0;
								state_q <= S_CLEAR;
							end
							default: begin
								state_q <= S_PUT;
							end
						endcase
					end
				end
				S_SCROLL: begin
					// the last scroll cycle leaves this low for the next scroll
					pend_s1 <= (32'(cnt_q) < SCROLL_N);
					if (32'(cnt_q) < SCROLL_N) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if ((32'(cnt_q) == SCROLL_N) && pend_s1) begin
						row_q   <= RW'(ROWS - 1);
						state_q <= S_WCHAR;
					end
				end
				S_WCHAR: begin
					if (is_nl) begin
						state_q <= S_NLFILL;
					end else begin
						state_q <= S_PUT;
						if (col_last) begin
							col_q <= '0;
							row_q <= row_q + RW'(1);
						end else begin
							col_q <= col_q + LW'(1);
						end
					end
				end
				S_NLFILL: begin
					if (col_last) begin
						col_q   <= '0;
						row_q   <= row_q + RW'(1);
						state_q <= S_PUT;
					end else begin
						col_q <= col_q + LW'(1);
					end
				end
				S_CLEAR: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(CELLS - 1)) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers: no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			code_q <= char_code;
		end
		waddr_s1 <= cnt_q[AW-1:0];
		if (out_load) begin
			read_code  <= rd_sel_q ? rdata_q.code : 8'd0;
			read_fore  <= rd_sel_q ? rdata_q.fore : 4'd0;
			read_back  <= rd_sel_q ? rdata_q.back : 4'd0;
			cursor_row <= row_x[4:0];
			cursor_col <= col_x[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

@@ hdl/tcw_checker.sv @@
// Port-level checker of the text console writer and its bind.
module tcw_checker #(
	parameter int ROWS = tcw_pkg::ROWS_DEF,
	parameter int COLS = tcw_pkg::COLS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [7:0]  cfg_index,
	input logic [3:0]  cfg_data,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  op,
	input logic [7:0]  char_code,
	input logic [10:0] cell_index,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  read_code,
	input logic [3:0]  read_fore,
	input logic [3:0]  read_back,
	input logic [4:0]  cursor_row,
	input logic [6:0]  cursor_col
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_code) && $stable(read_fore)
			&& $stable(read_back) && $stable(cursor_row) && $stable(cursor_col))
		else $error("result changed while stalled");

	// one item at a time: an accepted item blocks the next
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after accepting an item");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(cursor_col) < COLS))
		else $error("cursor column out of range");

	// a pending scroll only follows a wrap or a newline
	a_scroll_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (ROWS < 32) && (32'(cursor_row) == ROWS) |-> (cursor_col == 7'd0))
		else $error("pending scroll with cursor off column zero");

endmodule

bind text_console_writer_top tcw_checker #(.ROWS(ROWS), .COLS(COLS)) u_tcw_checker (.*);
